FILE: design/kvcs_pkg.sv
// kvcs_pkg: shared widths, constants and types of the key vector cosine scorer
// no dependencies; imported by every module of the block
`default_nettype none

package kvcs_pkg;

   localparam int COS_FRAC_BITS = 24;

   localparam int ELEM_W      = 16;
   localparam int NUM_VECS    = 5;
   localparam int VEC_LEN     = 3;
   localparam int NUM_LANES   = 4;
   localparam int KEY_W       = 240;
   localparam int MUL_W       = 2 * ELEM_W;
   localparam int DOT_W       = MUL_W + 2;
   localparam int PROD_W      = 2 * DOT_W;
   localparam int REM_W       = PROD_W + 1;
   localparam int QUO_W       = 2 * COS_FRAC_BITS + 1;
   localparam int COS_W       = COS_FRAC_BITS + 1;
   localparam int DIV_STAGES  = QUO_W;
   localparam int SQRT_STAGES = COS_W;
   localparam int LANE_LAT    = 3 + DIV_STAGES + SQRT_STAGES + 1;
   localparam int MERGE_LAT   = 5;
   localparam int TOTAL_LAT   = LANE_LAT + MERGE_LAT;

   localparam int SUM_W       = COS_W + 2;
   localparam int THR_W       = COS_W + 6;
   localparam int SCALE_W     = 32;
   localparam int NUM_W       = SUM_W + SCALE_W;
   localparam int MQ_W        = 32;
   localparam int RECIP_W     = 64;
   localparam int RECIP_SHIFT = 50;
   localparam int K_W         = 14;
   localparam int KP_W        = 33;
   localparam int REWARD_W    = 14;
   localparam int MAXC_W      = 25;
   localparam int MAXX_W      = (COS_W > MAXC_W) ? COS_W : MAXC_W;

   localparam logic [SCALE_W-1:0] SCALE_NUM  = 32'd4166666667;
   localparam logic [31:0]        RECIP      = 32'd2814749767;
   localparam logic [KP_W-1:0]    BIN        = 33'd400000;
   localparam logic [KP_W-1:0]    HALF_BIN   = 33'd200000;
   localparam logic [REWARD_W-1:0] BASE_REWARD = 14'd11000;
   localparam logic [THR_W-1:0]   THR_MUL    = THR_W'(50);
   localparam logic [THR_W-1:0]   THR_LIMIT  = THR_W'(9) << COS_FRAC_BITS;

   typedef logic [ELEM_W-1:0] elem_type;
   typedef elem_type [VEC_LEN-1:0] vec_type;
   typedef logic [COS_W-1:0] cos_type;

endpackage

`default_nettype wire

FILE: design/key_vector_cosine_scorer.sv
// key_vector_cosine_scorer: top level, unpacks the key into five 3-vectors and scores four pairs
// depends on kvcs_pkg, kvcs_lane, kvcs_merge
//
// One key word is taken in every cycle: busy stays low, so start alone accepts a word.
// Each word gives one result, shown on the rsp_ ports for one cycle with rsp_valid high.
// Each word passes through the four cosine lanes, each a one-bit-a-stage divider of
// 2F+1 stages followed by a one-bit-a-stage square root of F+1 stages, and then
// through five stages of the merging logic.
// The receiver cannot stall; results leave in acceptance order.
`default_nettype none

module key_vector_cosine_scorer
   import kvcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [63:0]         req_key_bytes_0_7,
   input  logic [63:0]         req_key_bytes_8_15,
   input  logic [63:0]         req_key_bytes_16_23,
   input  logic [47:0]         req_key_bytes_24_29,
   output logic                rsp_valid,
   output logic [REWARD_W-1:0] rsp_reward_milli,
   output logic                rsp_qualifies,
   output logic [MAXC_W-1:0]   rsp_max_cosine
);

   logic [KEY_W-1:0]     key_w;
   vec_type              vec_w [NUM_VECS];
   cos_type              cos_w [NUM_LANES];
   cos_type              max_w;
   logic [MAXX_W-1:0]    max_ext_w;
   logic [TOTAL_LAT-1:0] vld_ff, vld_in;

   assign busy  = 1'b0;
   assign key_w = {req_key_bytes_24_29, req_key_bytes_16_23,
                   req_key_bytes_8_15, req_key_bytes_0_7};

   always_comb begin
      for (int v = 0; v < NUM_VECS; v++) begin
         for (int e = 0; e < VEC_LEN; e++) begin
            vec_w[v][e] = key_w[ELEM_W*(VEC_LEN*v+e) +: ELEM_W];
         end
      end
   end

   // pairs (v0,v3) (v3,v2) (v2,v1) (v1,v4)
   kvcs_lane u_lane0 (.clock(clock), .vec_a(vec_w[0]), .vec_b(vec_w[3]), .cos_q(cos_w[0]));
   kvcs_lane u_lane1 (.clock(clock), .vec_a(vec_w[3]), .vec_b(vec_w[2]), .cos_q(cos_w[1]));
   kvcs_lane u_lane2 (.clock(clock), .vec_a(vec_w[2]), .vec_b(vec_w[1]), .cos_q(cos_w[2]));
   kvcs_lane u_lane3 (.clock(clock), .vec_a(vec_w[1]), .vec_b(vec_w[4]), .cos_q(cos_w[3]));

   kvcs_merge u_merge (
      .clock     (clock),
      .cos_q     (cos_w),
      .reward    (rsp_reward_milli),
      .qualifies (rsp_qualifies),
      .max_cos   (max_w)
   );

   assign max_ext_w      = MAXX_W'(max_w);
   assign rsp_max_cosine = max_ext_w[MAXC_W-1:0];

   // word valid travels alongside the datapath
   assign vld_in = {vld_ff[TOTAL_LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[TOTAL_LAT-1];

endmodule

`default_nettype wire

FILE: design/kvcs_lane.sv
// kvcs_lane: pipelined cosine of one vector pair, Q1.F, via restoring divide and square root
// depends on kvcs_pkg
`default_nettype none

module kvcs_lane
   import kvcs_pkg::*;
(
   input  logic    clock,
   input  vec_type vec_a,
   input  vec_type vec_b,
   output cos_type cos_q
);

   logic [MUL_W-1:0]  pab_ff [VEC_LEN];
   logic [MUL_W-1:0]  paa_ff [VEC_LEN];
   logic [MUL_W-1:0]  pbb_ff [VEC_LEN];
   logic [DOT_W-1:0]  dot_ff, n1_ff, n2_ff;
   logic [PROD_W-1:0] dsq_ff, prod_ff;
   logic              zero_ff;

   logic [REM_W-1:0]  rem_ff  [DIV_STAGES];
   logic [QUO_W-1:0]  quo_ff  [DIV_STAGES];
   logic [PROD_W-1:0] den_ff  [DIV_STAGES];
   logic              dz_ff   [DIV_STAGES];

   logic [QUO_W-1:0]  x_ff    [SQRT_STAGES];
   logic [QUO_W-1:0]  r_ff    [SQRT_STAGES];
   logic              sz_ff   [SQRT_STAGES];

   cos_type           cos_ff;

   // element products
   always_ff @(posedge clock) begin
      for (int k = 0; k < VEC_LEN; k++) begin
         pab_ff[k] <= MUL_W'(vec_a[k]) * MUL_W'(vec_b[k]);
         paa_ff[k] <= MUL_W'(vec_a[k]) * MUL_W'(vec_a[k]);
         pbb_ff[k] <= MUL_W'(vec_b[k]) * MUL_W'(vec_b[k]);
      end
   end

   // dot product and squared magnitudes
   always_ff @(posedge clock) begin
      dot_ff <= DOT_W'(pab_ff[0]) + DOT_W'(pab_ff[1]) + DOT_W'(pab_ff[2]);
      n1_ff  <= DOT_W'(paa_ff[0]) + DOT_W'(paa_ff[1]) + DOT_W'(paa_ff[2]);
      n2_ff  <= DOT_W'(pbb_ff[0]) + DOT_W'(pbb_ff[1]) + DOT_W'(pbb_ff[2]);
   end

   always_ff @(posedge clock) begin
      dsq_ff  <= PROD_W'(dot_ff) * PROD_W'(dot_ff);
      prod_ff <= PROD_W'(n1_ff) * PROD_W'(n2_ff);
      zero_ff <= (dot_ff == '0);
   end

   // quotient dot^2 * 2^(2F) / (n1*n2), one bit a stage
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      logic [REM_W-1:0]  part_w;
      logic [PROD_W-1:0] den_w;
      logic [QUO_W-1:0]  quo_w;
      logic              zero_w;
      logic              ge_w;

      if (i == 0) begin : g_first
         assign part_w = REM_W'(dsq_ff);
         assign den_w  = prod_ff;
         assign quo_w  = '0;
         assign zero_w = zero_ff;
      end else begin : g_next
         assign part_w = {rem_ff[i-1][REM_W-2:0], 1'b0};
         assign den_w  = den_ff[i-1];
         assign quo_w  = quo_ff[i-1];
         assign zero_w = dz_ff[i-1];
      end

      assign ge_w = (part_w >= REM_W'(den_w));

      always_ff @(posedge clock) begin
         rem_ff[i] <= ge_w ? (part_w - REM_W'(den_w)) : part_w;
         quo_ff[i] <= {quo_w[QUO_W-2:0], ge_w};
         den_ff[i] <= den_w;
         dz_ff[i]  <= zero_w;
      end
   end

   // integer square root of the quotient, one result bit a stage
   for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
      localparam logic [QUO_W-1:0] BIT = QUO_W'(1) << (2 * COS_FRAC_BITS - 2 * j);
      logic [QUO_W-1:0] x_w;
      logic [QUO_W-1:0] r_w;
      logic             zero_w;
      logic [QUO_W:0]   trial_w;
      logic             ge_w;

      if (j == 0) begin : g_first
         assign x_w    = quo_ff[DIV_STAGES-1];
         assign r_w    = '0;
         assign zero_w = dz_ff[DIV_STAGES-1];
      end else begin : g_next
         assign x_w    = x_ff[j-1];
         assign r_w    = r_ff[j-1];
         assign zero_w = sz_ff[j-1];
      end

      assign trial_w = (QUO_W+1)'(r_w) + (QUO_W+1)'(BIT);
      assign ge_w    = ((QUO_W+1)'(x_w) >= trial_w);

      always_ff @(posedge clock) begin
         x_ff[j]  <= ge_w ? (x_w - trial_w[QUO_W-1:0]) : x_w;
         r_ff[j]  <= ge_w ? ((r_w >> 1) + BIT) : (r_w >> 1);
         sz_ff[j] <= zero_w;
      end
   end

   // zero dot product scores as exactly one
   always_ff @(posedge clock) begin
      cos_ff <= sz_ff[SQRT_STAGES-1] ? (COS_W'(1) << COS_FRAC_BITS)
                                     : r_ff[SQRT_STAGES-1][COS_W-1:0];
   end

   assign cos_q = cos_ff;

endmodule

`default_nettype wire

FILE: design/kvcs_merge.sv
// kvcs_merge: combines the four lane cosines into maximum, threshold flag and reward
// depends on kvcs_pkg
`default_nettype none

module kvcs_merge
   import kvcs_pkg::*;
(
   input  logic                clock,
   input  cos_type             cos_q [NUM_LANES],
   output logic [REWARD_W-1:0] reward,
   output logic                qualifies,
   output cos_type             max_cos
);

   cos_type             m01_w, m23_w, mx_w;
   logic [NUM_LANES-1:0] below_w;

   logic [SUM_W-1:0]    sum1_ff;
   logic                ok1_ff, ok2_ff, ok3_ff, ok4_ff, ok5_ff;
   cos_type             mx1_ff, mx2_ff, mx3_ff, mx4_ff, mx5_ff;
   logic [NUM_W-1:0]    num2_ff;
   logic [RECIP_W-1:0]  mr3_ff;
   logic [MQ_W-1:0]     mq3_ff, mq4_ff;
   logic                lnz3_ff, lnz4_ff;
   logic [K_W-1:0]      k4_ff;
   logic [KP_W-1:0]     kp4_ff;
   logic [REWARD_W-1:0] reward5_ff;

   logic [MQ_W-1:0]     mq_w;
   logic [K_W-1:0]      k_w, k2_w;
   logic [KP_W-1:0]     rem_w, rem2_w;
   logic                adj_w, rnd_w;

   assign m01_w = (cos_q[0] > cos_q[1]) ? cos_q[0] : cos_q[1];
   assign m23_w = (cos_q[2] > cos_q[3]) ? cos_q[2] : cos_q[3];
   assign mx_w  = (m01_w > m23_w) ? m01_w : m23_w;

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         below_w[l] = (THR_W'(cos_q[l]) * THR_MUL) < THR_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      sum1_ff <= SUM_W'(cos_q[0]) + SUM_W'(cos_q[1]) + SUM_W'(cos_q[2]) + SUM_W'(cos_q[3]);
      ok1_ff  <= &below_w;
      mx1_ff  <= mx_w;
   end

   always_ff @(posedge clock) begin
      num2_ff <= NUM_W'(sum1_ff) * NUM_W'(SCALE_NUM);
      ok2_ff  <= ok1_ff;
      mx2_ff  <= mx1_ff;
   end

   // integer part over 2^F, then quotient estimate by 400000 via reciprocal
   assign mq_w = num2_ff[COS_FRAC_BITS +: MQ_W];

   always_ff @(posedge clock) begin
      mr3_ff  <= RECIP_W'(mq_w) * RECIP_W'(RECIP);
      mq3_ff  <= mq_w;
      lnz3_ff <= |num2_ff[COS_FRAC_BITS-1:0];
      ok3_ff  <= ok2_ff;
      mx3_ff  <= mx2_ff;
   end

   assign k_w = mr3_ff[RECIP_SHIFT +: K_W];

   always_ff @(posedge clock) begin
      kp4_ff  <= KP_W'(k_w) * BIN;
      k4_ff   <= k_w;
      mq4_ff  <= mq3_ff;
      lnz4_ff <= lnz3_ff;
      ok4_ff  <= ok3_ff;
      mx4_ff  <= mx3_ff;
   end

   // estimate may be one short
   assign rem_w  = KP_W'(mq4_ff) - kp4_ff;
   assign adj_w  = (rem_w >= BIN);
   assign rem2_w = adj_w ? (rem_w - BIN) : rem_w;
   assign k2_w   = k4_ff + K_W'(adj_w);
   assign rnd_w  = (rem2_w > HALF_BIN) || ((rem2_w == HALF_BIN) && lnz4_ff);

   always_ff @(posedge clock) begin
      reward5_ff <= ok4_ff ? (BASE_REWARD - REWARD_W'(k2_w) - REWARD_W'(rnd_w)) : '0;
      ok5_ff     <= ok4_ff;
      mx5_ff     <= mx4_ff;
   end

   assign reward    = reward5_ff;
   assign qualifies = ok5_ff;
   assign max_cos   = mx5_ff;

endmodule

`default_nettype wire

FILE: design/kvcs_checker.sv
// kvcs_checker: port-level checks on the scorer, attached to the top level by bind
// depends on kvcs_pkg and key_vector_cosine_scorer
`default_nettype none

module kvcs_checker
   import kvcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                rsp_valid,
   input  logic [REWARD_W-1:0] rsp_reward_milli,
   input  logic                rsp_qualifies,
   input  logic [MAXC_W-1:0]   rsp_max_cosine
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_valid_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, TOTAL_LAT))
      else $error("result word without an accepted key");

   a_zero_reward: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_qualifies) |-> (rsp_reward_milli == '0))
      else $error("reward on a key that does not qualify");

   a_reward_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_qualifies) |->
         (rsp_reward_milli >= REWARD_W'(1000) && rsp_reward_milli <= BASE_REWARD))
      else $error("reward out of range");

   a_cosine_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_max_cosine <= (MAXC_W'(1) << COS_FRAC_BITS)))
      else $error("largest cosine above one");

endmodule

bind key_vector_cosine_scorer kvcs_checker u_kvcs_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_reward_milli (rsp_reward_milli),
   .rsp_qualifies    (rsp_qualifies),
   .rsp_max_cosine   (rsp_max_cosine)
);

`default_nettype wire
